// File: rtl/tcoe_pkg.sv
// ----------------------------------------------------------------------------
// tcoe_pkg
// shared types and constants of the trimmed clock offset estimator
// ----------------------------------------------------------------------------
package tcoe_pkg;

	localparam int MAX_SAMPLES = 128;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int DATA_W      = 48;
	localparam int SUM_W       = 56;
	localparam int DCNT_W      = $clog2(SUM_W);
	localparam int TRIM_W      = 6;
	localparam int NOISE_W     = 8;
	localparam logic [NOISE_W-1:0] NOISE_RESET = 8'd9;

	// floor(x/3) = (x*171) >> 9 for x below 512
	localparam int THIRD_MUL = 171;
	localparam int THIRD_SH  = 9;

	typedef struct packed {
		logic signed [DATA_W-1:0] forward_diff;
		logic signed [DATA_W-1:0] return_diff;
		logic                     last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] clock_offset;
		logic signed [DATA_W-1:0] one_way_latency;
		logic                     offset_suppressed;
		logic                     too_few_samples;
		logic                     overflowed;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic pivot;
		logic issue;
		logic add;
		logic div_start;
		logic div_step;
		logic fix;
		logic mul;
		logic cmp;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic last_acc;
		logic few;
		logic sweep_last;
		logic item_last;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// File: rtl/tcoe_sample_if.sv
// ----------------------------------------------------------------------------
// tcoe_sample_if
// valid/ready channel carrying one pair of timestamp differences
// ----------------------------------------------------------------------------
interface tcoe_sample_if;
	logic               valid;
	logic               ready;
	tcoe_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tcoe_result_if.sv
// ----------------------------------------------------------------------------
// tcoe_result_if
// valid/ready channel carrying one offset estimate
// ----------------------------------------------------------------------------
interface tcoe_result_if;
	logic                valid;
	logic                ready;
	tcoe_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/trimmed_clock_offset_estimator.sv
// ----------------------------------------------------------------------------
// trimmed_clock_offset_estimator
// two-way time transfer offset and latency from a trimmed mean of samples
// ----------------------------------------------------------------------------
// sample channel: one pair of forward/return differences per transaction,
// taken one per cycle while loading; last_sample closes the set. up to
// 128 pairs are stored, further pairs are dropped and flagged as overflow.
// after the closing pair the block stops taking samples while it works:
// each stored pair is ranked against all others by a sweep over the store
// (second read port) after a setup step; then come a serial divider, the
// noise test and the output. a set of fewer than two pairs skips the rank
// sweep and the divider.
// result channel: one transaction per set, held in an output register until
// taken; a stalled receiver holds the block at the end of the next set.
// reset clears the fill count, overflow flag and handshake state and sets
// noise_factor_sq to 9; stored samples are not cleared.
// cfg_wr_en/cfg_wr_data write noise_factor_sq; the user must write it only
// while the block is idle, which the block itself leaves unchecked.
// ----------------------------------------------------------------------------
module trimmed_clock_offset_estimator (
	input  logic                         clk,
	input  logic                         arst_n,
	tcoe_sample_if.sink                  sample,
	tcoe_result_if.source                result,
	input  logic                         cfg_wr_en,
	input  logic [tcoe_pkg::NOISE_W-1:0] cfg_wr_data
);
	tcoe_pkg::cmd_t cmd;
	tcoe_pkg::sts_t sts;

	tcoe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample.valid),
		.in_ready(sample.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tcoe_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_item    (sample.data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_item   (result.data)
	);
endmodule

// File: rtl/tcoe_ram.sv
// ----------------------------------------------------------------------------
// tcoe_ram
// one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module tcoe_ram #(
	parameter int W     = 96,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [W-1:0]             rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [W-1:0]             rdata_b
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

// File: rtl/tcoe_ctrl.sv
// ----------------------------------------------------------------------------
// tcoe_ctrl
// sequencer: load, rank sweep, trimmed sum, divide, noise test, output
// ----------------------------------------------------------------------------
module tcoe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tcoe_pkg::sts_t sts,
	output tcoe_pkg::cmd_t cmd
);
	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_PIVOT = 4'd2;
	localparam logic [3:0] S_SWEEP = 4'd3;
	localparam logic [3:0] S_TALLY = 4'd4;
	localparam logic [3:0] S_ADD   = 4'd5;
	localparam logic [3:0] S_DIVST = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIX   = 4'd8;
	localparam logic [3:0] S_MUL   = 4'd9;
	localparam logic [3:0] S_CMP   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.load      = (state_q == S_LOAD) && in_valid;
		cmd.prep      = (state_q == S_PREP);
		cmd.pivot     = (state_q == S_PIVOT);
		cmd.issue     = (state_q == S_SWEEP);
		cmd.add       = (state_q == S_ADD);
		cmd.div_start = (state_q == S_DIVST);
		cmd.div_step  = (state_q == S_DIV);
		cmd.fix       = (state_q == S_FIX);
		cmd.mul       = (state_q == S_MUL);
		cmd.cmp       = (state_q == S_CMP);
		cmd.fin       = (state_q == S_FIN) && !sts.out_busy;
		case (state_q)
			S_LOAD: begin
				if (sts.last_acc) state_d = S_PREP;
			end
			S_PREP: begin
				state_d = sts.few ? S_FIN : S_PIVOT;
			end
			S_PIVOT: state_d = S_SWEEP;
			S_SWEEP: begin
				if (sts.sweep_last) state_d = S_TALLY;
			end
			S_TALLY: state_d = S_ADD;
			S_ADD: begin
				state_d = sts.item_last ? S_DIVST : S_PIVOT;
			end
			S_DIVST: state_d = S_DIV;
			S_DIV: begin
				if (sts.div_done) state_d = S_FIX;
			end
			S_FIX: state_d = S_MUL;
			S_MUL: state_d = S_CMP;
			S_CMP: state_d = S_FIN;
			S_FIN: begin
				if (!sts.out_busy) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/tcoe_dp.sv
// ----------------------------------------------------------------------------
// tcoe_dp
// sample store, rank counters, trimmed sums, serial divider, noise test
// ----------------------------------------------------------------------------
module tcoe_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcoe_pkg::cmd_t                    cmd,
	output tcoe_pkg::sts_t                    sts,
	input  tcoe_pkg::in_item_t                in_item,
	input  logic                              cfg_wr_en,
	input  logic [tcoe_pkg::NOISE_W-1:0]      cfg_wr_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tcoe_pkg::out_item_t               out_item
);
	localparam int DW = tcoe_pkg::DATA_W;
	localparam int SW = tcoe_pkg::SUM_W;
	localparam int IW = tcoe_pkg::IDX_W;
	localparam int CW = tcoe_pkg::CNT_W;
	localparam int TW = tcoe_pkg::TRIM_W;

	logic [tcoe_pkg::NOISE_W-1:0] noise_q;
	logic [CW-1:0] count_q, n_q;
	logic          ovf_q, ovf_res_q, few_q;
	logic          full;
	logic [IW-1:0] i_q, j_q, j_s1;
	logic          cmp_v_s1;
	logic [IW:0]   start_q, end_q;
	logic [TW-1:0] cnt_q;
	logic [IW:0]   rankf_q, rankr_q;
	logic signed [SW-1:0] sumf_q, sumr_q;
	logic [2*DW-1:0] rd_a, rd_b;
	logic signed [DW-1:0] pf, pr, bf, br;
	logic          tie;
	logic [SW-1:0] qf_q, ql_q;
	logic [TW:0]   remf_q, reml_q;
	logic [TW+1:0] remf_x, reml_x;
	logic          negf_q, negl_q;
	logic [tcoe_pkg::DCNT_W-1:0] dcnt_q;
	logic signed [SW-1:0] xf, xl;
	logic [SW-1:0] hf, hl;
	logic signed [DW-1:0] off_q, lat_q;
	logic [DW-1:0] aoff, alat;
	logic [SW-1:0] sq_q, thr_q;
	logic          small_q, latnz_q, supp_q, outv_q;
	logic [15:0]   third_a, third_b;

	assign full = (count_q == CW'(tcoe_pkg::MAX_SAMPLES));

	tcoe_ram #(.W(2*DW), .DEPTH(tcoe_pkg::MAX_SAMPLES)) u_ram (
		.clk    (clk),
		.we     (cmd.load && !full),
		.waddr  (count_q[IW-1:0]),
		.wdata  ({in_item.forward_diff, in_item.return_diff}),
		.raddr_a(i_q),
		.rdata_a(rd_a),
		.raddr_b(j_q),
		.rdata_b(rd_b)
	);

	assign pf  = rd_a[2*DW-1:DW];
	assign pr  = rd_a[DW-1:0];
	assign bf  = rd_b[2*DW-1:DW];
	assign br  = rd_b[DW-1:0];
	assign tie = (j_s1 < i_q);

	assign third_a = 16'(n_q) * 16'(tcoe_pkg::THIRD_MUL);
	assign third_b = 16'({n_q, 1'b0}) * 16'(tcoe_pkg::THIRD_MUL);

	assign sts.last_acc   = cmd.load && in_item.last_sample;
	assign sts.few        = (n_q < CW'(2));
	assign sts.sweep_last = ({1'b0, j_q} == n_q - CW'(1));
	assign sts.item_last  = ({1'b0, i_q} == n_q - CW'(1));
	assign sts.div_done   = (dcnt_q == '0);
	assign sts.out_busy   = outv_q;

	assign xf = sumf_q + sumr_q;
	assign xl = sumf_q - sumr_q;
	assign hf = qf_q >> 1;
	assign hl = ql_q >> 1;
	assign remf_x = {remf_q, qf_q[SW-1]};
	assign reml_x = {reml_q, ql_q[SW-1]};
	assign aoff = off_q[DW-1] ? DW'(-off_q) : DW'(off_q);
	assign alat = lat_q[DW-1] ? DW'(-lat_q) : DW'(lat_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q  <= tcoe_pkg::NOISE_RESET;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			cmp_v_s1 <= 1'b0;
			outv_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) noise_q <= cfg_wr_data;
			cmp_v_s1 <= cmd.issue;
			if (cmd.load) begin
				if (in_item.last_sample) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (outv_q && out_ready) outv_q <= 1'b0;
			else if (cmd.fin) outv_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load && in_item.last_sample) begin
			n_q       <= full ? count_q : count_q + CW'(1);
			ovf_res_q <= ovf_q || full;
		end
		if (cmd.prep) begin
			start_q <= (IW+1)'(third_a >> tcoe_pkg::THIRD_SH);
			end_q   <= (IW+1)'(third_b >> tcoe_pkg::THIRD_SH);
			cnt_q   <= TW'((third_b >> tcoe_pkg::THIRD_SH) - (third_a >> tcoe_pkg::THIRD_SH));
			few_q   <= (n_q < CW'(2));
			i_q     <= '0;
			sumf_q  <= '0;
			sumr_q  <= '0;
		end
		if (cmd.pivot) begin
			j_q     <= '0;
			rankf_q <= '0;
			rankr_q <= '0;
		end
		if (cmd.issue) j_q <= j_q + IW'(1);
		j_s1 <= j_q;
		// rank = number of elements ordered before the pivot, ties by index
		if (cmp_v_s1) begin
			if (bf < pf || (bf == pf && tie)) rankf_q <= rankf_q + (IW+1)'(1);
			if (br < pr || (br == pr && tie)) rankr_q <= rankr_q + (IW+1)'(1);
		end
		if (cmd.add) begin
			if (rankf_q >= start_q && rankf_q < end_q)
				sumf_q <= sumf_q + {{(SW-DW){pf[DW-1]}}, pf};
			if (rankr_q >= start_q && rankr_q < end_q)
				sumr_q <= sumr_q + {{(SW-DW){pr[DW-1]}}, pr};
			i_q <= i_q + IW'(1);
		end
		if (cmd.div_start) begin
			negf_q <= xf[SW-1];
			negl_q <= xl[SW-1];
			qf_q   <= xf[SW-1] ? SW'(-xf) : SW'(xf);
			ql_q   <= xl[SW-1] ? SW'(-xl) : SW'(xl);
			remf_q <= '0;
			reml_q <= '0;
			dcnt_q <= tcoe_pkg::DCNT_W'(SW - 1);
		end
		// restoring division, one quotient bit per cycle
		if (cmd.div_step) begin
			if (remf_x >= {2'b00, cnt_q}) begin
				remf_q <= (TW+1)'(remf_x - {2'b00, cnt_q});
				qf_q   <= {qf_q[SW-2:0], 1'b1};
			end else begin
				remf_q <= remf_x[TW:0];
				qf_q   <= {qf_q[SW-2:0], 1'b0};
			end
			if (reml_x >= {2'b00, cnt_q}) begin
				reml_q <= (TW+1)'(reml_x - {2'b00, cnt_q});
				ql_q   <= {ql_q[SW-2:0], 1'b1};
			end else begin
				reml_q <= reml_x[TW:0];
				ql_q   <= {ql_q[SW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - tcoe_pkg::DCNT_W'(1);
		end
		if (cmd.fix) begin
			off_q <= negf_q ? DW'(-hf) : DW'(hf);
			lat_q <= negl_q ? DW'(-hl) : DW'(hl);
		end
		if (cmd.mul) begin
			small_q <= (aoff[DW-1:28] == '0);
			latnz_q <= (alat != '0);
			sq_q    <= SW'(aoff[27:0]) * SW'(aoff[27:0]);
			thr_q   <= SW'(noise_q) * SW'(alat);
		end
		if (cmd.cmp) supp_q <= latnz_q && small_q && (sq_q < thr_q);
		if (cmd.fin) begin
			out_item.too_few_samples   <= few_q;
			out_item.overflowed        <= ovf_res_q;
			out_item.offset_suppressed <= !few_q && supp_q;
			out_item.clock_offset      <= (few_q || supp_q) ? '0 : off_q;
			out_item.one_way_latency   <= few_q ? '0 : lat_q;
		end
	end

	assign out_valid = outv_q;
endmodule

// File: rtl/tcoe_checker.sv
// ----------------------------------------------------------------------------
// tcoe_checker
// port-level checks of the estimator, bound to the top level
// ----------------------------------------------------------------------------
module tcoe_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_last,
	input logic                      out_valid,
	input logic                      out_ready,
	input tcoe_pkg::out_item_t       out_item
);
	// a pending result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// closing a set stops sample intake
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("sample taken right after closing pair");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.too_few_samples |->
		out_item.clock_offset == '0 && out_item.one_way_latency == '0 &&
		!out_item.offset_suppressed)
		else $error("too few samples with nonzero fields");

	a_supp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.offset_suppressed |-> out_item.clock_offset == '0)
		else $error("suppressed offset not zero");
endmodule

bind trimmed_clock_offset_estimator tcoe_checker u_tcoe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sample.valid),
	.in_ready (sample.ready),
	.in_last  (sample.data.last_sample),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_item (result.data)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the trimmed clock offset estimator: directed pairs
// at the field extremes and corner cases, then random sample sets under
// several noise thresholds, checked against an in-bench trimmed-mean model
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [tcoe_pkg::DATA_W-1:0] f;
		logic signed [tcoe_pkg::DATA_W-1:0] r;
		bit                                 last;
		bit                                 typed;
		tcoe_pkg::out_item_t                want;
	} pair_row_t;

	localparam logic signed [tcoe_pkg::DATA_W-1:0] D_MAX =
		{1'b0, {(tcoe_pkg::DATA_W-1){1'b1}}};
	localparam logic signed [tcoe_pkg::DATA_W-1:0] D_MIN =
		{1'b1, {(tcoe_pkg::DATA_W-1){1'b0}}};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [tcoe_pkg::NOISE_W-1:0] cfg_wr_data;

	tcoe_sample_if sample_ch ();
	tcoe_result_if result_ch ();

	trimmed_clock_offset_estimator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// bench copy of the block state
	logic signed [tcoe_pkg::DATA_W-1:0] fwd_mem [tcoe_pkg::MAX_SAMPLES];
	logic signed [tcoe_pkg::DATA_W-1:0] ret_mem [tcoe_pkg::MAX_SAMPLES];
	int unsigned                        fill_cnt;
	bit                                 drop_seen;
	logic [tcoe_pkg::NOISE_W-1:0]       noise_sq;

	tcoe_pkg::out_item_t estimate_q [$];
	pair_row_t           pair_rows [$];
	int                  errors;
	int                  items_sent;
	bit                  quiet;
	bit                  hold_req;
	int                  hold_left;
	int                  stall_left;
	bit                  cur_typed;
	tcoe_pkg::out_item_t cur_want;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic tcoe_pkg::out_item_t trimmed_estimate();
		tcoe_pkg::out_item_t      res;
		longint                   lst [2][tcoe_pkg::MAX_SAMPLES];
		longint                   sum [2];
		longint                   off, lat, v;
		longint unsigned          aoff, alat;
		int                       n, lo, hi, cnt, i, j, k;
		bit                       supp;
		res = '0;
		res.overflowed = drop_seen;
		n = fill_cnt;
		fill_cnt = 0;
		drop_seen = 1'b0;
		if (n < 2) begin
			res.too_few_samples = 1'b1;
			return res;
		end
		for (i = 0; i < n; i++) begin
			lst[0][i] = fwd_mem[i];
			lst[1][i] = ret_mem[i];
		end
		lo = n / 3;
		hi = (2 * n) / 3;
		cnt = hi - lo;
		for (k = 0; k < 2; k++) begin
			for (i = 1; i < n; i++) begin
				v = lst[k][i];
				j = i;
				while (j > 0 && lst[k][j-1] > v) begin
					lst[k][j] = lst[k][j-1];
					j--;
				end
				lst[k][j] = v;
			end
			sum[k] = 0;
			for (i = lo; i < hi; i++)
				sum[k] += lst[k][i];
		end
		off = ((sum[0] + sum[1]) / longint'(cnt)) / 2;
		lat = ((sum[0] - sum[1]) / longint'(cnt)) / 2;
		aoff = (off < 0) ? longint'(-off) : off;
		alat = (lat < 0) ? longint'(-lat) : lat;
		supp = 1'b0;
		if (alat != 0 && aoff < (64'd1 << 28))
			supp = (aoff * aoff) < (longint'(noise_sq) * alat);
		res.clock_offset = supp ? '0 : off[tcoe_pkg::DATA_W-1:0];
		res.one_way_latency = lat[tcoe_pkg::DATA_W-1:0];
		res.offset_suppressed = supp;
		return res;
	endfunction

	function automatic void add_row(logic signed [tcoe_pkg::DATA_W-1:0] f,
			logic signed [tcoe_pkg::DATA_W-1:0] r,
			bit last, bit typed, tcoe_pkg::out_item_t want);
		pair_row_t row;
		row.f = f;
		row.r = r;
		row.last = last;
		row.typed = typed;
		row.want = want;
		pair_rows = {pair_rows, row};
	endfunction

	function automatic logic signed [tcoe_pkg::DATA_W-1:0] rand_diff();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return w[tcoe_pkg::DATA_W-1:0];
			1: return $signed(tcoe_pkg::DATA_W'($urandom_range(0, 2000))) - 1000;
			2: return $signed(tcoe_pkg::DATA_W'($urandom)) - 48'sd2147483648;
			default: return $urandom_range(0, 1) ? D_MAX - $urandom_range(0, 3)
				: D_MIN + $urandom_range(0, 3);
		endcase
	endfunction

	// input side: mirror every accepted transaction into the bench state
	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			if (fill_cnt < tcoe_pkg::MAX_SAMPLES) begin
				fwd_mem[fill_cnt] = sample_ch.data.forward_diff;
				ret_mem[fill_cnt] = sample_ch.data.return_diff;
				fill_cnt++;
			end else begin
				drop_seen = 1'b1;
			end
			if (sample_ch.data.last_sample) begin
				if (cur_typed) begin
					void'(trimmed_estimate());
					estimate_q = {estimate_q, cur_want};
				end else begin
					estimate_q = {estimate_q, trimmed_estimate()};
				end
			end
		end
	end

	// output side
	always @(posedge clk) begin
		tcoe_pkg::out_item_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (estimate_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transaction %p", result_ch.data);
			end else begin
				want = estimate_q.pop_front();
				if (result_ch.data !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p", want, result_ch.data);
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (quiet) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 17);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_pair(logic signed [tcoe_pkg::DATA_W-1:0] f,
			logic signed [tcoe_pkg::DATA_W-1:0] r,
			bit last, bit typed, tcoe_pkg::out_item_t want);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= '{forward_diff: f, return_diff: r, last_sample: last};
		cur_typed = typed;
		cur_want = want;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_set(int n);
		logic signed [tcoe_pkg::DATA_W-1:0] base_off, base_lat, jit;
		int                                 mode, i;
		mode = $urandom_range(0, 2);
		base_off = $signed(tcoe_pkg::DATA_W'($urandom_range(0, 4000))) - 2000;
		base_lat = $urandom_range(0, 100000);
		for (i = 0; i < n; i++) begin
			jit = $signed(tcoe_pkg::DATA_W'($urandom_range(0, 200))) - 100;
			if (mode == 0)
				send_pair(rand_diff(), rand_diff(), i == n - 1, 1'b0, '0);
			else
				send_pair(base_off + base_lat + jit, base_off - base_lat + jit * mode,
					i == n - 1, 1'b0, '0);
		end
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (estimate_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_noise(logic [tcoe_pkg::NOISE_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		noise_sq = val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [tcoe_pkg::NOISE_W-1:0] cfg_vals [6];
		int                           ph, target, len;
		tcoe_pkg::out_item_t          few, zero_all;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		fill_cnt = 0;
		drop_seen = 1'b0;
		noise_sq = tcoe_pkg::NOISE_RESET;
		errors = 0;
		items_sent = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		stall_left = 0;
		cur_typed = 1'b0;
		cur_want = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		few = '0;
		few.too_few_samples = 1'b1;
		zero_all = '0;
		add_row(48'sd5, 48'sd7, 1'b1, 1'b1, few);
		add_row(D_MAX, D_MIN, 1'b0, 1'b0, '0);
		add_row(D_MIN, D_MAX, 1'b1, 1'b0, '0);
		add_row(D_MIN, D_MIN, 1'b0, 1'b0, '0);
		add_row(D_MIN, D_MIN, 1'b1, 1'b0, '0);
		add_row(D_MAX, D_MAX, 1'b0, 1'b0, '0);
		add_row(D_MAX, D_MAX, 1'b1, 1'b0, '0);
		add_row(48'sd0, 48'sd0, 1'b0, 1'b0, '0);
		add_row(48'sd0, 48'sd0, 1'b1, 1'b1, zero_all);
		// zero offset with nonzero latency still reports suppression
		add_row(48'sd100, -48'sd100, 1'b0, 1'b0, '0);
		add_row(48'sd100, -48'sd100, 1'b1, 1'b1, '{48'sd0, 48'sd100, 1'b1, 1'b0, 1'b0});
		// zero latency never suppresses
		add_row(48'sd500, 48'sd500, 1'b0, 1'b0, '0);
		add_row(48'sd500, 48'sd500, 1'b1, 1'b1, '{48'sd500, 48'sd0, 1'b0, 1'b0, 1'b0});
		add_row(48'sd1, 48'sd2, 1'b0, 1'b0, '0);
		add_row(-48'sd3, 48'sd4, 1'b0, 1'b0, '0);
		add_row(48'sd9, -48'sd8, 1'b1, 1'b0, '0);
		add_row(48'h555555555555, 48'hAAAAAAAAAAAA, 1'b0, 1'b0, '0);
		add_row(48'hAAAAAAAAAAAA, 48'h555555555555, 1'b0, 1'b0, '0);
		add_row(48'h555555555555, 48'h555555555555, 1'b1, 1'b0, '0);
		foreach (pair_rows[i])
			send_pair(pair_rows[i].f, pair_rows[i].r, pair_rows[i].last,
				pair_rows[i].typed, pair_rows[i].want);

		cfg_vals = '{8'd0, 8'd255, 8'd1, 8'd9, 8'($urandom_range(2, 254)), 8'd255};
		for (ph = 0; ph < 6; ph++) begin
			drain();
			write_noise(cfg_vals[ph]);
			quiet = (ph == 5);
			target = items_sent + 60;
			if (ph == 2) begin
				// long receiver hold-off while sets keep coming
				hold_req = 1'b1;
				repeat (4) send_set($urandom_range(2, 6));
			end
			if (ph == 3) begin
				send_set(tcoe_pkg::MAX_SAMPLES);
				send_set(tcoe_pkg::MAX_SAMPLES + 1);
				send_set(tcoe_pkg::MAX_SAMPLES + 3);
				target = items_sent + 10;
			end
			while (items_sent < target) begin
				case ($urandom_range(0, 9))
					0: len = 1;
					1, 2: len = $urandom_range(13, 40);
					default: len = $urandom_range(2, 12);
				endcase
				send_set(len);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tcoe_pkg.sv
rtl/tcoe_sample_if.sv
rtl/tcoe_result_if.sv
rtl/tcoe_ram.sv
rtl/tcoe_ctrl.sv
rtl/tcoe_dp.sv
rtl/trimmed_clock_offset_estimator.sv
rtl/tcoe_checker.sv
tb/tb.sv
